// ===== rtl/core/odo_pkg.sv =====
// odo_pkg: shared types and constants of the differential-drive odometry block
// covers fixed-point angle constants, the cordic arctangent table and the sequencer states
// no dependencies
package odo_pkg;

  // port widths
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int COUNT_W    = 16;
  localparam int POSE_W     = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LINEAR_GAIN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_GAIN = 1'd1;

  // multiplier operand and product widths
  localparam int MUL_IN_W  = 33;
  localparam int MUL_OUT_W = 65;

  // angle datapath, Q30 radians
  localparam int ANG_W         = 48;
  localparam int CORDIC_STEPS  = 24;
  localparam int REDUCE_STEPS  = 15;
  localparam int CNT_W         = 5;

  localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
  localparam logic [32:0] PI_Q30      = 33'd3373259426;
  localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
  // two pi minus half pi: upper edge of the band that folds by subtracting pi
  localparam logic [32:0] FOLD_HI_Q30 = 33'd5059889139;
  localparam logic [31:0] CORDIC_K    = 32'd652032874;

  // bias that keeps the mid angle positive before reduction: 2pi << 14
  localparam logic [ANG_W-1:0] ANG_BIAS = {15'd0, TWO_PI_Q30} << 14;

  // saturation limits
  localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  // arctangent of 2^-i in Q30
  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  // cordic sequencer
  typedef enum logic [2:0] {
    CS_IDLE,
    CS_REDUCE,
    CS_FOLD,
    CS_ROTATE,
    CS_DONE
  } cordic_state_t;

  // top level sequencer
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_D,
    ST_MUL_W,
    ST_ANGLE,
    ST_START,
    ST_ROT,
    ST_MUL_DX,
    ST_MUL_DY,
    ST_UPDATE,
    ST_DONE
  } odo_state_t;

  // multiplier operand select
  typedef enum logic [1:0] {
    MS_LIN,
    MS_ANG,
    MS_COS,
    MS_SIN
  } mul_sel_t;

  // control word from the sequencer to the datapath
  typedef struct packed {
    logic     in_stall;
    logic     accept;
    mul_sel_t mul_sel;
    logic     load_d;
    logic     load_w;
    logic     cor_start;
    logic     add_dx;
    logic     add_dy;
    logic     load_out;
  } odo_ctrl_t;

endpackage

// ===== rtl/core/odo_mul.sv =====
// odo_mul: shared signed multiplier with a registered product
// depends on odo_pkg for operand and product widths
module odo_mul (
  input  logic                                 clk,
  input  logic signed [odo_pkg::MUL_IN_W-1:0]  a,
  input  logic signed [odo_pkg::MUL_IN_W-1:0]  b,
  output logic signed [odo_pkg::MUL_OUT_W-1:0] p
);
  import odo_pkg::*;

  logic signed [MUL_OUT_W-1:0] p_r;
  logic signed [MUL_OUT_W-1:0] p_nxt;

  // full-width signed product
  always_comb begin
    p_nxt = a * b;
  end

  // product register
  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

  assign p = p_r;

endmodule

// ===== rtl/core/odo_cordic.sv =====
// odo_cordic: iterative angle reduction and rotation-mode cordic for cos and sin
// one shared 48-bit adder serves both the modulo-2pi reduction and the z updates
// depends on odo_pkg for constants, the arctangent table and the state type
module odo_cordic (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [odo_pkg::ANG_W-1:0]       ang,
  output logic                            done,
  output logic signed [31:0]              cos_val,
  output logic signed [31:0]              sin_val
);
  import odo_pkg::*;

  cordic_state_t state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [ANG_W-1:0]        z_r, z_nxt;
  logic signed [31:0]      x_r, x_nxt;
  logic signed [31:0]      y_r, y_nxt;
  logic                    neg_r, neg_nxt;

  logic [ANG_W-1:0]        add_b;
  logic                    add_sub;
  logic [ANG_W:0]          add_res;
  logic signed [31:0]      x_sh;
  logic signed [31:0]      y_sh;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_IDLE:   if (start) state_nxt = CS_REDUCE;
      CS_REDUCE: if (cnt_r == '0) state_nxt = CS_FOLD;
      CS_FOLD:   state_nxt = CS_ROTATE;
      CS_ROTATE: if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) state_nxt = CS_DONE;
      CS_DONE:   state_nxt = CS_IDLE;
      default:   state_nxt = CS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done    = (state_r == CS_DONE);
    cos_val = neg_r ? -x_r : x_r;
    sin_val = neg_r ? -y_r : y_r;
  end

  // shared adder: trial subtract of 2pi << k while reducing, z -/+ atan while rotating
  always_comb begin
    if (state_r == CS_REDUCE) begin
      add_b   = {15'd0, TWO_PI_Q30} << cnt_r;
      add_sub = 1'b1;
    end else begin
      add_b   = {16'd0, ATAN_TAB[cnt_r]};
      add_sub = ~z_r[ANG_W-1];
    end
    if (add_sub) begin
      add_res = {1'b0, z_r} - {1'b0, add_b};
    end else begin
      add_res = {1'b0, z_r} + {1'b0, add_b};
    end
  end

  assign x_sh = x_r >>> cnt_r;
  assign y_sh = y_r >>> cnt_r;

  // datapath
  always_comb begin
    cnt_nxt = cnt_r;
    z_nxt   = z_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    neg_nxt = neg_r;
    unique case (state_r)
      CS_IDLE: begin
        if (start) begin
          z_nxt   = ang;
          cnt_nxt = CNT_W'(REDUCE_STEPS - 1);
          x_nxt   = CORDIC_K;
          y_nxt   = '0;
          neg_nxt = 1'b0;
        end
      end
      CS_REDUCE: begin
        // keep the difference when no borrow
        if (!add_res[ANG_W]) z_nxt = add_res[ANG_W-1:0];
        if (cnt_r != '0) cnt_nxt = cnt_r - 1'b1;
      end
      CS_FOLD: begin
        // z is in [0, 2pi): bring it to [-pi/2, pi/2], negating when pi is removed
        cnt_nxt = '0;
        if (z_r[32:0] <= HALF_PI_Q30) begin
          z_nxt   = z_r;
          neg_nxt = 1'b0;
        end else if (z_r[32:0] < FOLD_HI_Q30) begin
          z_nxt   = z_r - {15'd0, PI_Q30};
          neg_nxt = 1'b1;
        end else begin
          z_nxt   = z_r - {15'd0, TWO_PI_Q30};
          neg_nxt = 1'b0;
        end
      end
      CS_ROTATE: begin
        if (!z_r[ANG_W-1]) begin
          x_nxt = x_r - y_sh;
          y_nxt = y_r + x_sh;
        end else begin
          x_nxt = x_r + y_sh;
          y_nxt = y_r - x_sh;
        end
        z_nxt   = add_res[ANG_W-1:0];
        cnt_nxt = cnt_r + 1'b1;
      end
      CS_DONE: begin
        cnt_nxt = '0;
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    z_r   <= z_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    neg_r <= neg_nxt;
  end

endmodule

// ===== rtl/core/diff_drive_odometry_top.sv =====
// diff_drive_odometry_top: dead-reckoning pose tracker for a two-wheel robot
// depends on odo_pkg, odo_mul (shared multiplier) and odo_cordic (angle unit)
//
// Input channel in_*: valid/stall. in_cmd = 0 is an encoder tick carrying
// left and right counts; in_cmd = 1 stores a pending pose correction.
// Result channel out_*: one result per input item with the pose after it.
// Config port cfg_*: write linear_gain (index 0) and angular_gain (index 1)
// while the block is idle; writes take effect at once.
// A tick that integrates runs two multiplies on the shared 33x33 multiplier,
// then 15 reduction steps and 24 rotation steps on the cordic adder with a
// fold between them, then two more multiplies and the pose update.
// A correction item, or a tick that applies a pending correction, skips the
// multiplies and the cordic. One item is worked on at a time; in_stall
// is high while an item is in progress.
// The result sits in an output register: a new item is taken while it waits,
// and the block holds its next result until the receiver drops out_stall.
// Reset (rst_n low, synchronous) clears pose, gains and any pending correction.
module diff_drive_odometry_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration port
  input  logic                              cfg_we,
  input  logic [odo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [odo_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_cmd,
  input  logic signed [odo_pkg::COUNT_W-1:0] in_left_count,
  input  logic signed [odo_pkg::COUNT_W-1:0] in_right_count,
  input  logic signed [odo_pkg::POSE_W-1:0] in_new_x,
  input  logic signed [odo_pkg::POSE_W-1:0] in_new_y,
  input  logic signed [odo_pkg::POSE_W-1:0] in_new_heading,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [odo_pkg::POSE_W-1:0] out_pos_x,
  output logic signed [odo_pkg::POSE_W-1:0] out_pos_y,
  output logic signed [odo_pkg::POSE_W-1:0] out_heading,
  output logic                              out_corrected
);
  import odo_pkg::*;

  // round a Q.28 product to Q16.16 and saturate to 32 bits
  function automatic logic signed [31:0] round_sat(input logic signed [MUL_OUT_W-1:0] p);
    logic signed [MUL_OUT_W-1:0] rnd;
    rnd = p + MUL_OUT_W'(2048);
    if ((&rnd[MUL_OUT_W-1:43]) || !(|rnd[MUL_OUT_W-1:43])) begin
      return rnd[43:12];
    end else if (rnd[MUL_OUT_W-1]) begin
      return SAT_MIN;
    end else begin
      return SAT_MAX;
    end
  endfunction

  // round a Q46 product to Q16.16, keeping the low 32 bits
  function automatic logic [31:0] round_step(input logic signed [MUL_OUT_W-1:0] p);
    logic signed [MUL_OUT_W-1:0] rnd;
    rnd = p + (MUL_OUT_W'(1) << 29);
    return rnd[61:30];
  endfunction

  odo_state_t state_r, state_nxt;
  odo_ctrl_t  ctrl;

  logic [31:0]        lin_gain_r, lin_gain_nxt;
  logic [31:0]        ang_gain_r, ang_gain_nxt;
  logic [31:0]        x_r, x_nxt;
  logic [31:0]        y_r, y_nxt;
  logic [31:0]        h_r, h_nxt;
  logic               pend_flag_r, pend_flag_nxt;
  logic [31:0]        pend_x_r, pend_x_nxt;
  logic [31:0]        pend_y_r, pend_y_nxt;
  logic [31:0]        pend_h_r, pend_h_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               corr_r, corr_nxt;
  logic signed [16:0] sum_r, sum_nxt;
  logic signed [16:0] diff_r, diff_nxt;
  logic signed [31:0] d_r, d_nxt;
  logic signed [31:0] w_r, w_nxt;
  logic [31:0]        out_x_r, out_y_r, out_h_r;
  logic               out_corr_r;

  logic signed [MUL_IN_W-1:0]  mul_a, mul_b;
  logic signed [MUL_OUT_W-1:0] mul_p;
  logic [ANG_W-1:0]            mid_ang;
  logic                        cor_done;
  logic signed [31:0]          cor_cos, cor_sin;
  logic                        out_free;

  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd || pend_flag_r) state_nxt = ST_DONE;
          else state_nxt = ST_MUL_D;
        end
      end
      ST_MUL_D:  state_nxt = ST_MUL_W;
      ST_MUL_W:  state_nxt = ST_ANGLE;
      ST_ANGLE:  state_nxt = ST_START;
      ST_START:  state_nxt = ST_ROT;
      ST_ROT:    if (cor_done) state_nxt = ST_MUL_DX;
      ST_MUL_DX: state_nxt = ST_MUL_DY;
      ST_MUL_DY: state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl           = '0;
    ctrl.in_stall  = (state_r != ST_IDLE);
    ctrl.mul_sel   = MS_LIN;
    unique case (state_r)
      ST_IDLE:   ctrl.accept    = in_valid;
      ST_MUL_D:  ctrl.mul_sel   = MS_LIN;
      ST_MUL_W: begin
        ctrl.mul_sel = MS_ANG;
        ctrl.load_d  = 1'b1;
      end
      ST_ANGLE:  ctrl.load_w    = 1'b1;
      ST_START:  ctrl.cor_start = 1'b1;
      ST_ROT:    ctrl.mul_sel   = MS_COS;
      ST_MUL_DX: ctrl.mul_sel   = MS_COS;
      ST_MUL_DY: begin
        ctrl.mul_sel = MS_SIN;
        ctrl.add_dx  = 1'b1;
      end
      ST_UPDATE: ctrl.add_dy    = 1'b1;
      ST_DONE:   ctrl.load_out  = out_free;
      default:   ctrl.mul_sel   = MS_LIN;
    endcase
  end

  assign in_stall = ctrl.in_stall;

  // multiplier operand select
  always_comb begin
    unique case (ctrl.mul_sel)
      MS_LIN: begin
        mul_a = $signed({1'b0, lin_gain_r});
        mul_b = {{16{sum_r[16]}}, sum_r};
      end
      MS_ANG: begin
        mul_a = $signed({1'b0, ang_gain_r});
        mul_b = {{16{diff_r[16]}}, diff_r};
      end
      MS_COS: begin
        mul_a = {d_r[31], d_r};
        mul_b = {cor_cos[31], cor_cos};
      end
      MS_SIN: begin
        mul_a = {d_r[31], d_r};
        mul_b = {cor_sin[31], cor_sin};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  odo_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // mid-step angle in Q30: heading*2^14 + w*2^13, biased positive by 2pi*2^14
  assign mid_ang = {{2{h_r[31]}}, h_r, 14'd0}
                 + {{3{w_r[31]}}, w_r, 13'd0}
                 + ANG_BIAS;

  odo_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (ctrl.cor_start),
    .ang     (mid_ang),
    .done    (cor_done),
    .cos_val (cor_cos),
    .sin_val (cor_sin)
  );

  // configuration writes
  always_comb begin
    lin_gain_nxt = lin_gain_r;
    ang_gain_nxt = ang_gain_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_LINEAR_GAIN:  lin_gain_nxt = cfg_wdata;
        REG_ANGULAR_GAIN: ang_gain_nxt = cfg_wdata;
        default:          lin_gain_nxt = lin_gain_r;
      endcase
    end
  end

  // pose, pending correction and working values
  always_comb begin
    x_nxt         = x_r;
    y_nxt         = y_r;
    h_nxt         = h_r;
    pend_flag_nxt = pend_flag_r;
    pend_x_nxt    = pend_x_r;
    pend_y_nxt    = pend_y_r;
    pend_h_nxt    = pend_h_r;
    corr_nxt      = corr_r;
    sum_nxt       = sum_r;
    diff_nxt      = diff_r;
    d_nxt         = d_r;
    w_nxt         = w_r;

    if (ctrl.accept) begin
      corr_nxt = 1'b0;
      priority if (in_cmd) begin
        // store a correction, later ones overwrite
        pend_x_nxt    = in_new_x;
        pend_y_nxt    = in_new_y;
        pend_h_nxt    = in_new_heading;
        pend_flag_nxt = 1'b1;
      end else if (pend_flag_r) begin
        // apply the correction, zero components keep the pose
        if (pend_x_r != '0) x_nxt = pend_x_r;
        if (pend_y_r != '0) y_nxt = pend_y_r;
        if (pend_h_r != '0) h_nxt = pend_h_r;
        pend_flag_nxt = 1'b0;
        corr_nxt      = 1'b1;
      end else begin
        sum_nxt  = 17'(in_left_count) + 17'(in_right_count);
        diff_nxt = 17'(in_right_count) - 17'(in_left_count);
      end
    end

    if (ctrl.load_d) d_nxt = round_sat(mul_p);
    if (ctrl.load_w) w_nxt = round_sat(mul_p);
    if (ctrl.add_dx) x_nxt = x_r + round_step(mul_p);
    if (ctrl.add_dy) begin
      y_nxt = y_r + round_step(mul_p);
      h_nxt = h_r + w_r;
    end
  end

  // result register handshake
  always_comb begin
    if (ctrl.load_out) out_valid_nxt = 1'b1;
    else out_valid_nxt = out_valid_r && out_stall;
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lin_gain_r  <= '0;
      ang_gain_r  <= '0;
      x_r         <= '0;
      y_r         <= '0;
      h_r         <= '0;
      pend_flag_r <= 1'b0;
      pend_x_r    <= '0;
      pend_y_r    <= '0;
      pend_h_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lin_gain_r  <= lin_gain_nxt;
      ang_gain_r  <= ang_gain_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      h_r         <= h_nxt;
      pend_flag_r <= pend_flag_nxt;
      pend_x_r    <= pend_x_nxt;
      pend_y_r    <= pend_y_nxt;
      pend_h_r    <= pend_h_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    corr_r <= corr_nxt;
    sum_r  <= sum_nxt;
    diff_r <= diff_nxt;
    d_r    <= d_nxt;
    w_r    <= w_nxt;
  end

  // result payload
  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      out_x_r    <= x_r;
      out_y_r    <= y_r;
      out_h_r    <= h_r;
      out_corr_r <= corr_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pos_x     = out_x_r;
  assign out_pos_y     = out_y_r;
  assign out_heading   = out_h_r;
  assign out_corrected = out_corr_r;

`ifndef SYNTH
  // the angle unit only finishes while the sequencer waits for it
  a_cordic_done_in_rot: assert property (@(posedge clk) disable iff (!rst_n)
    cor_done |-> state_r == ST_ROT)
    else $error("cordic finished outside the rotate wait");

  // a correction transfer leaves a pending correction
  a_corr_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_cmd) |=> pend_flag_r)
    else $error("correction transfer did not set pending flag");

  // a plain tick transfer starts integration
  a_tick_integrates: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_cmd && !pend_flag_r) |=> state_r == ST_MUL_D)
    else $error("tick transfer did not start integration");
`endif

endmodule
